// ===== sv/neighbour_sequence_table_assert.svh =====
// Assertion macros shared by the neighbour sequence table modules.
`ifndef NEIGHBOUR_SEQUENCE_TABLE_ASSERT_SVH
`define NEIGHBOUR_SEQUENCE_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/nst_pkg.sv =====
// Shared types and constants of the neighbour sequence table.
package nst_pkg;

    localparam int MAX_NEIGHBOURS_DEF = 16;
    localparam int MAX_FRAME_BYTES    = 127;

    localparam logic [6:0]  PAYLOAD_BYTES = 7'd6;
    localparam logic [15:0] KEY_RESET     = 16'haa;

    localparam logic [1:0] ST_REJECTED = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_UPDATED  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [6:0]  frame_length;
        logic [15:0] beacon_key;
        logic [15:0] sender_id;
        logic [15:0] sequence_req;
    } beacon_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] previous_sequence;
        logic        gap_seen;
        logic [15:0] missed_beacons;
    } result_t;

    typedef struct packed {
        logic        start;
        logic [15:0] sender;
        logic [15:0] seq_num;
    } table_req_t;

    typedef struct packed {
        logic    done;
        result_t res;
    } table_rsp_t;

endpackage

// ===== sv/nst_table.sv =====
// Neighbour table memory with its sequential lookup and update engine.
module nst_table #(
    parameter int MAX_NEIGHBOURS = nst_pkg::MAX_NEIGHBOURS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nst_pkg::table_req_t req,
    output nst_pkg::table_rsp_t rsp
);

    localparam int IDX_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(MAX_NEIGHBOURS);

    typedef struct packed {
        logic [15:0] sender;
        logic [15:0] seq_num;
    } entry_t;

    typedef enum logic {
        IDLE,
        SCAN
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [15:0] id_reg, seq_reg;

    entry_t mem [MAX_NEIGHBOURS];
    entry_t rd_data_reg;

    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    entry_t           wr_data;

    logic        match;
    logic [16:0] prev_plus_one;
    logic        gap;

    // Entries fill contiguously from index 0, so an entry is valid exactly
    // when its index lies below the fill count.
    assign match         = (rd_data_reg.sender == id_reg);
    assign prev_plus_one = {1'b0, rd_data_reg.seq_num} + 17'd1;
    assign gap           = ({1'b0, seq_reg} > prev_plus_one);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        chk_idx_next = chk_idx_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = fill_reg[IDX_W-1:0];
        wr_data      = '{sender: id_reg, seq_num: seq_reg};
        rsp          = '0;

        unique case (state_reg)
            IDLE:
            begin
                if (req.start)
                begin
                    if (fill_reg == '0)
                    begin
                        wr_en              = 1'b1;
                        wr_addr            = '0;
                        wr_data            = '{sender: req.sender, seq_num: req.seq_num};
                        fill_next          = CNT_W'(1);
                        rsp.done           = 1'b1;
                        rsp.res.status     = nst_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        chk_idx_next = '0;
                        idx_next     = CNT_W'(1);
                        state_next   = SCAN;
                    end
                end
            end
            SCAN:
            begin
                if (match)
                begin
                    wr_en                     = 1'b1;
                    wr_addr                   = chk_idx_reg;
                    wr_data                   = '{sender: rd_data_reg.sender,
                                                  seq_num: seq_reg};
                    rsp.done                  = 1'b1;
                    rsp.res.status            = nst_pkg::ST_UPDATED;
                    rsp.res.previous_sequence = rd_data_reg.seq_num;
                    rsp.res.gap_seen          = gap;
                    rsp.res.missed_beacons    = gap ? (seq_reg - prev_plus_one[15:0]) : '0;
                    state_next                = IDLE;
                end
                else if (idx_reg < fill_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg[IDX_W-1:0];
                    chk_idx_next = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                end
                else
                begin
                    rsp.done   = 1'b1;
                    state_next = IDLE;
                    if (fill_reg < FILL_MAX)
                    begin
                        wr_en          = 1'b1;
                        fill_next      = fill_reg + CNT_W'(1);
                        rsp.res.status = nst_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        rsp.res.status = nst_pkg::ST_FULL;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            fill_reg    <= '0;
            idx_reg     <= '0;
            chk_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            chk_idx_reg <= chk_idx_next;
        end
    end

    // The beacon under lookup is held here for the whole scan.
    always_ff @(posedge clk)
    begin
        if (state_reg == IDLE && req.start)
        begin
            id_reg  <= req.sender;
            seq_reg <= req.seq_num;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`include "neighbour_sequence_table_assert.svh"

    `NST_ASSERT_NOW(fill_in_range, 1'b1, fill_reg <= FILL_MAX, "fill count beyond table depth")
    `NST_ASSERT_NOW(scan_below_fill, state_reg == SCAN, idx_reg <= fill_reg && fill_reg != '0,
                    "scan index past fill count")
    `NST_ASSERT_NOW(write_not_read, wr_en, !rd_en, "table read and write in one cycle")
    `NST_ASSERT_NEXT(full_keeps_fill, rsp.done && rsp.res.status == nst_pkg::ST_FULL,
                     fill_reg == FILL_MAX, "table full reported while not full")

endmodule

// ===== sv/neighbour_sequence_table.sv =====
// Top level of the beacon neighbour sequence table.
// A rejected beacon, or a new neighbour into an empty table, needs no table scan;
// otherwise the scan reads one table entry from the memory per cycle. Each result
// passes through the pending register and then the output register. One beacon at
// a time: beacon_stall holds further beacons off until the result reaches the output.
// Reset: asynchronous and active low; empties the table and sets the key to 0xaa.
module neighbour_sequence_table #(
    parameter int MAX_NEIGHBOURS = nst_pkg::MAX_NEIGHBOURS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    input  logic             beacon_valid,
    output logic             beacon_stall,
    input  nst_pkg::beacon_t beacon,
    output logic             result_valid,
    input  logic             result_stall,
    output nst_pkg::result_t result
);

    // The user must write the key register only while the block is idle; the block does not enforce it.
    logic [15:0] key_reg;

    // Busy covers a transaction from acceptance until its result has moved
    // into the output register, so only one beacon is ever in the table
    // engine and no memory accesses of two beacons can overlap.
    logic busy_reg;

    // Pending result: taken either straight from the acceptance check when
    // the beacon is rejected, or from the table engine when it finishes.
    nst_pkg::result_t pend_reg;
    logic             pend_valid_reg;

    nst_pkg::result_t result_reg;
    logic             result_valid_reg;

    logic                accept;
    logic                beacon_ok;
    logic                out_free;
    nst_pkg::table_req_t req;
    nst_pkg::table_rsp_t rsp;

    assign beacon_stall = busy_reg;
    assign accept       = beacon_valid && !busy_reg;

    // A beacon is kept only when its frame carries exactly the payload and
    // its key matches the configured one.
    assign beacon_ok = (beacon.frame_length == nst_pkg::PAYLOAD_BYTES) &&
                       (beacon.beacon_key == key_reg);

    assign req.start   = accept && beacon_ok;
    assign req.sender  = beacon.sender_id;
    assign req.seq_num = beacon.sequence_req;

    // The output register is free when empty or being taken this cycle.
    assign out_free = !result_valid_reg || !result_stall;

    nst_table #(
        .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
    ) u_table (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg          <= nst_pkg::KEY_RESET;
            busy_reg         <= 1'b0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                key_reg <= cfg_wdata;
            end

            if (accept)
            begin
                busy_reg <= 1'b1;
            end

            if (accept && !beacon_ok)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (rsp.done)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_valid_reg && out_free)
            begin
                pend_valid_reg <= 1'b0;
                busy_reg       <= 1'b0;
            end

            if (pend_valid_reg && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (accept && !beacon_ok)
        begin
            pend_reg <= '{status: nst_pkg::ST_REJECTED, previous_sequence: 16'd0,
                          gap_seen: 1'b0, missed_beacons: 16'd0};
        end
        else if (rsp.done)
        begin
            pend_reg <= rsp.res;
        end

        if (pend_valid_reg && out_free)
        begin
            result_reg <= pend_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`include "neighbour_sequence_table_assert.svh"

    `NST_ASSERT_NOW(done_while_busy, rsp.done, (busy_reg || accept) && !pend_valid_reg,
                    "table finished without a transaction in flight")
    `NST_ASSERT_NOW(pending_is_busy, pend_valid_reg, busy_reg,
                    "pending result outside a transaction")
    `NST_ASSERT_NEXT(accept_sets_busy, accept, busy_reg && !beacon_stall == 1'b0,
                     "beacon accepted without blocking the next one")

endmodule
